>>> rtl/core/lcdwf_pkg.sv
// shared types, constants and codes of the window fill and glyph blit engine
// used by every module under rtl/core
package lcdwf_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;
    localparam int MAX_GLYPH     = 72;

    localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int DIM_W      = $clog2(SCREEN_MAX + 1);
    localparam int GLYPH_W    = 7;
    localparam int REPEAT_W   = 21;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int NPIX_W     = 4;
    localparam int BEAT_W     = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    typedef enum logic [1:0] {
        OP_FILL        = 2'd0,
        OP_GLYPH_START = 2'd1,
        OP_GLYPH_BYTE  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        JOB_FILL   = 2'd0,
        JOB_GLYPH  = 2'd1,
        JOB_PIXELS = 2'd2
    } t_job_kind;

    // transfer slots of a window sequence
    localparam logic [BEAT_W-1:0] BEAT_COL_CMD  = 4'd0;
    localparam logic [BEAT_W-1:0] BEAT_X1_HI    = 4'd1;
    localparam logic [BEAT_W-1:0] BEAT_X1_LO    = 4'd2;
    localparam logic [BEAT_W-1:0] BEAT_X2_HI    = 4'd3;
    localparam logic [BEAT_W-1:0] BEAT_X2_LO    = 4'd4;
    localparam logic [BEAT_W-1:0] BEAT_ROW_CMD  = 4'd5;
    localparam logic [BEAT_W-1:0] BEAT_Y1_HI    = 4'd6;
    localparam logic [BEAT_W-1:0] BEAT_Y1_LO    = 4'd7;
    localparam logic [BEAT_W-1:0] BEAT_Y2_HI    = 4'd8;
    localparam logic [BEAT_W-1:0] BEAT_Y2_LO    = 4'd9;
    localparam logic [BEAT_W-1:0] BEAT_MEM_CMD  = 4'd10;
    localparam logic [BEAT_W-1:0] BEAT_FILL_WRD = 4'd11;

    typedef struct packed {
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] x_last;
        logic [COORD_W-1:0] y_last;
        logic [GLYPH_W-1:0] glyph_width;
        logic [GLYPH_W-1:0] glyph_height;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] back_color;
        logic [7:0]         bitmap_byte;
    } t_req;

    typedef struct packed {
        t_job_kind          kind;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
        logic [DIM_W-1:0]   dx;
        logic [DIM_W-1:0]   dy;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [7:0]         bits;
        logic [NPIX_W-1:0]  npix;
        logic               done;
    } t_job;

    typedef struct packed {
        logic                is_data;
        logic                wide_word;
        logic [COLOR_W-1:0]  value;
        logic [REPEAT_W-1:0] repeat_res;
        logic                window_done;
        logic                last;
    } t_xfer;

endpackage

>>> rtl/core/lcdwf_front.sv
// front end: takes draw requests, checks bounds, tracks glyph progress
// and hands jobs to the queue; depends on lcdwf_pkg
module lcdwf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [1:0]             i_op,
    input  lcdwf_pkg::t_req        i_req,
    input  logic                   i_q_full,
    output logic                   o_ready,
    output logic                   o_push,
    output lcdwf_pkg::t_job        o_job
);
    import lcdwf_pkg::*;

    logic               r_active;
    logic [GLYPH_W-1:0] r_width;
    logic [GLYPH_W-1:0] r_height;
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [GLYPH_W-1:0] r_col;
    logic [GLYPH_W-1:0] r_row;

    logic               w_acc;
    logic               w_fill_ok;
    logic               w_glyph_ok;
    logic [COORD_W:0]   w_xe;
    logic [COORD_W:0]   w_ye;
    logic [GLYPH_W-1:0] w_rem;
    logic               w_row_end;
    logic               w_glyph_end;
    logic [GLYPH_W-1:0] n_col;
    logic [GLYPH_W-1:0] n_row;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;

    assign w_fill_ok = (i_req.x_first < COORD_W'(SCREEN_WIDTH))
                    && (i_req.x_last < COORD_W'(SCREEN_WIDTH))
                    && (i_req.y_first < COORD_W'(SCREEN_HEIGHT))
                    && (i_req.y_last < COORD_W'(SCREEN_HEIGHT))
                    && (i_req.x_first <= i_req.x_last)
                    && (i_req.y_first <= i_req.y_last);

    assign w_xe = {1'b0, i_req.x_first} + (COORD_W+1)'(i_req.glyph_width) - 17'd1;
    assign w_ye = {1'b0, i_req.y_first} + (COORD_W+1)'(i_req.glyph_height) - 17'd1;

    assign w_glyph_ok = (i_req.glyph_width != '0) && (i_req.glyph_height != '0)
                     && (i_req.glyph_width <= GLYPH_W'(MAX_GLYPH))
                     && (i_req.glyph_height <= GLYPH_W'(MAX_GLYPH))
                     && (w_xe < (COORD_W+1)'(SCREEN_WIDTH))
                     && (w_ye < (COORD_W+1)'(SCREEN_HEIGHT));

    // pixels left in the current glyph row
    assign w_rem       = r_width - r_col;
    assign w_row_end   = (w_rem <= GLYPH_W'(8));
    assign w_glyph_end = w_row_end && ({1'b0, r_row} + 8'd1 >= {1'b0, r_height});
    assign n_col       = w_row_end ? '0 : r_col + GLYPH_W'(8);
    assign n_row       = w_glyph_end ? '0 : (w_row_end ? r_row + GLYPH_W'(1) : r_row);

    always_comb begin
        o_push      = 1'b0;
        o_job       = '0;
        o_job.kind  = JOB_FILL;
        o_job.x1    = i_req.x_first;
        o_job.y1    = i_req.y_first;
        o_job.x2    = i_req.x_last;
        o_job.y2    = i_req.y_last;
        o_job.dx    = DIM_W'(i_req.x_last - i_req.x_first + 16'd1);
        o_job.dy    = DIM_W'(i_req.y_last - i_req.y_first + 16'd1);
        o_job.fg    = i_req.color;
        o_job.bg    = r_bg;
        o_job.bits  = i_req.bitmap_byte;
        o_job.npix  = w_row_end ? NPIX_W'(w_rem) : NPIX_W'(8);
        o_job.done  = w_glyph_end;
        case (i_op)
            OP_FILL: begin
                o_push = w_acc && w_fill_ok;
            end
            OP_GLYPH_START: begin
                o_job.kind = JOB_GLYPH;
                o_job.x2   = w_xe[COORD_W-1:0];
                o_job.y2   = w_ye[COORD_W-1:0];
                o_push     = w_acc && w_glyph_ok;
            end
            OP_GLYPH_BYTE: begin
                o_job.kind = JOB_PIXELS;
                o_job.fg   = r_fg;
                o_push     = w_acc && r_active;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_fg     <= '0;
            r_bg     <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (w_acc) begin
            case (i_op)
                OP_FILL: begin
                    if (w_fill_ok) begin
                        r_active <= 1'b0;
                    end
                end
                OP_GLYPH_START: begin
                    r_active <= w_glyph_ok;
                    if (w_glyph_ok) begin
                        r_width  <= i_req.glyph_width;
                        r_height <= i_req.glyph_height;
                        r_fg     <= i_req.color;
                        r_bg     <= i_req.back_color;
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                end
                OP_GLYPH_BYTE: begin
                    if (r_active) begin
                        r_col <= n_col;
                        r_row <= n_row;
                        if (w_glyph_end) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

    a_glyph_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_col < r_width) && (r_row < r_height))
        else $error("glyph position outside stored geometry");

endmodule

>>> rtl/core/lcdwf_queue.sv
// short job queue between front end and transfer sequencer
// depends on lcdwf_pkg
module lcdwf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdwf_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output lcdwf_pkg::t_job   o_job
);
    import lcdwf_pkg::*;

    t_job            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QC_W'(1);
                2'b01:   r_count <= r_count - QC_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

endmodule

>>> rtl/core/lcdwf_back.sv
// transfer sequencer: expands one job into link words and holds the
// output register; depends on lcdwf_pkg
module lcdwf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  lcdwf_pkg::t_job   i_q_job,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output lcdwf_pkg::t_xfer  o_xfer
);
    import lcdwf_pkg::*;

    logic                  r_busy;
    t_job                  r_job;
    logic [BEAT_W-1:0]     r_beat;
    logic [REPEAT_W-1:0]   r_area;
    logic                  r_out_valid;
    t_xfer                 r_xfer;

    logic [2*DIM_W-1:0]    w_prod;
    logic [BEAT_W-1:0]     w_fin_beat;
    logic                  w_go;
    logic                  w_emit;
    logic                  w_fin;
    logic                  w_load;
    t_xfer                 n_xfer;

    assign w_prod = r_job.dx * r_job.dy;

    always_comb begin
        case (r_job.kind)
            JOB_FILL:   w_fin_beat = BEAT_FILL_WRD;
            JOB_GLYPH:  w_fin_beat = BEAT_MEM_CMD;
            JOB_PIXELS: w_fin_beat = BEAT_W'(r_job.npix - NPIX_W'(1));
            default:    w_fin_beat = BEAT_MEM_CMD;
        endcase
    end

    assign w_go    = !r_out_valid || i_ready;
    assign w_emit  = r_busy && w_go;
    assign w_fin   = w_emit && (r_beat == w_fin_beat);
    assign w_load  = i_q_valid && (!r_busy || w_fin);
    assign o_q_pop = w_load;

    always_comb begin
        n_xfer             = '0;
        n_xfer.is_data     = 1'b1;
        n_xfer.repeat_res  = REPEAT_W'(1);
        n_xfer.last        = (r_beat == w_fin_beat);
        if (r_job.kind == JOB_PIXELS) begin
            n_xfer.wide_word   = 1'b1;
            n_xfer.value       = r_job.bits[3'd7 - r_beat[2:0]] ? r_job.fg : r_job.bg;
            n_xfer.window_done = r_job.done && (r_beat == w_fin_beat);
        end else begin
            case (r_beat)
                BEAT_COL_CMD: begin
                    n_xfer.is_data = 1'b0;
                    n_xfer.value   = {8'h00, CMD_COLUMN_SET};
                end
                BEAT_X1_HI: n_xfer.value = {8'h00, r_job.x1[15:8]};
                BEAT_X1_LO: n_xfer.value = {8'h00, r_job.x1[7:0]};
                BEAT_X2_HI: n_xfer.value = {8'h00, r_job.x2[15:8]};
                BEAT_X2_LO: n_xfer.value = {8'h00, r_job.x2[7:0]};
                BEAT_ROW_CMD: begin
                    n_xfer.is_data = 1'b0;
                    n_xfer.value   = {8'h00, CMD_ROW_SET};
                end
                BEAT_Y1_HI: n_xfer.value = {8'h00, r_job.y1[15:8]};
                BEAT_Y1_LO: n_xfer.value = {8'h00, r_job.y1[7:0]};
                BEAT_Y2_HI: n_xfer.value = {8'h00, r_job.y2[15:8]};
                BEAT_Y2_LO: n_xfer.value = {8'h00, r_job.y2[7:0]};
                BEAT_MEM_CMD: begin
                    n_xfer.is_data = 1'b0;
                    n_xfer.value   = {8'h00, CMD_MEMORY_WRITE};
                end
                BEAT_FILL_WRD: begin
                    n_xfer.wide_word   = 1'b1;
                    n_xfer.value       = r_job.fg;
                    n_xfer.repeat_res  = r_area;
                    n_xfer.window_done = 1'b1;
                end
                default: n_xfer.value = '0;
            endcase
        end
    end

    // area settles long before the colour word slot
    always_ff @(posedge i_clk) begin
        r_area <= REPEAT_W'(w_prod);
        if (w_load) begin
            r_job <= i_q_job;
        end
        if (w_emit) begin
            r_xfer <= n_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_out_valid <= r_busy;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_beat <= '0;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end else if (w_emit) begin
                r_beat <= r_beat + BEAT_W'(1);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_xfer  = r_xfer;

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_beat <= w_fin_beat))
        else $error("sequencer ran past final slot");

    a_npix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_job.kind == JOB_PIXELS)) |->
            (r_job.npix != '0) && (r_job.npix <= NPIX_W'(8)))
        else $error("pixel job with bad pixel count");

    a_load_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_fin) |-> !o_q_pop)
        else $error("job taken while sequencer busy");

endmodule

>>> rtl/core/lcd_window_fill_and_glyph_blit.sv
// Window fill and monochrome glyph blit engine. A draw request is taken and,
// if accepted, queued (four jobs deep) for the transfer sequencer, which
// sends one link word per cycle while the output is taken: a fill gives 12
// words, a glyph start 11, a bitmap byte 1 to 8 (the pixels left in its row).
// Rejected requests, idle bitmap bytes and unused ops are taken and give no
// word. Sustained rate is set by the sequencer's one word per cycle.
// top level: unpacks the stream words and joins front end, queue and sequencer
// depends on lcdwf_pkg, lcdwf_front, lcdwf_queue, lcdwf_back
module lcd_window_fill_and_glyph_blit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x_first, y_first, x_last, y_last, glyph_width, glyph_height, color,
    // back_color, bitmap_byte, zero pad
    input  logic [lcdwf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [lcdwf_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // value, repeat_res, window_done, zero pad
    output logic [lcdwf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // is_data, wide_word
    output logic [lcdwf_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                              m_axis_tlast
);
    import lcdwf_pkg::*;

    t_req   w_req;
    t_job   w_push_job;
    t_job   w_head_job;
    t_xfer  w_xfer;
    logic   w_push;
    logic   w_full;
    logic   w_head_valid;
    logic   w_pop;

    assign w_req.x_first      = s_axis_tdata[15:0];
    assign w_req.y_first      = s_axis_tdata[31:16];
    assign w_req.x_last       = s_axis_tdata[47:32];
    assign w_req.y_last       = s_axis_tdata[63:48];
    assign w_req.glyph_width  = s_axis_tdata[70:64];
    assign w_req.glyph_height = s_axis_tdata[77:71];
    assign w_req.color        = s_axis_tdata[93:78];
    assign w_req.back_color   = s_axis_tdata[109:94];
    assign w_req.bitmap_byte  = s_axis_tdata[117:110];

    lcdwf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser),
        .i_req    (w_req),
        .i_q_full (w_full),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    lcdwf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_job   (w_head_job)
    );

    lcdwf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_head_valid),
        .i_q_job   (w_head_job),
        .o_q_pop   (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_xfer    (w_xfer)
    );

    assign m_axis_tdata = {2'b00, w_xfer.window_done, w_xfer.repeat_res, w_xfer.value};
    assign m_axis_tuser = {w_xfer.wide_word, w_xfer.is_data};
    assign m_axis_tlast = w_xfer.last;

endmodule
